FILE: sv/erpp_pkg.sv
// Shared constants, types and the quarter-wave sine table for the point rotator.
`default_nettype none
package erpp_pkg;

    localparam int COEF_FRAC_BITS = 14;
    localparam int COORD_WIDTH    = 16;

    localparam int SIN_W   = COEF_FRAC_BITS + 1;          // table magnitude, 0..2^F
    localparam int COEF_W  = COEF_FRAC_BITS + 2;          // signed Q2.F coefficient
    localparam int PROD_W  = 2 * COEF_W;                  // sine * sine
    localparam int TRIP_W  = 3 * COEF_W + 1;              // sine^3 plus aligned sine^2
    localparam int MUL_W   = COORD_WIDTH + COEF_W;        // coordinate * coefficient
    localparam int ACC_W   = MUL_W + 2;                   // three products summed
    localparam int OUT_W   = 26;
    localparam int OUT_FRAC_SHIFT = COEF_FRAC_BITS - 8;
    localparam int ANGLE_W = 9;
    localparam int TAB_IDX_W = 7;
    localparam int TAB_LAST  = 90;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = 2'd2;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [TAB_LAST:0][SIN_W-1:0] sine_tab_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
    } coef_set_t;

    // Q2.30 Taylor series of sin for 0..90 degrees, rounded to QF.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        tab = '0;
        for (int d = 0; d <= TAB_LAST; d++) begin
            x    = (64'(d) * PI_Q30) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if ((n % 2) == 1) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            if (sum > (64'sd1 <<< 30)) begin
                sum = 64'sd1 <<< 30;
            end
            sum = (sum + (64'sd1 <<< (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
            tab[d] = sum[SIN_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

FILE: sv/euler_rotate_project_points_top.sv
// Top level: Euler X/Y/Z rotation and orthographic projection of grid points.
`default_nettype none
// Takes one point per clock unless a stall or rebuild holds it, and returns its projected
// screen x and y through the multiply, row sum and shift/saturate stages, with the
// last-point mark carried along. Output stalls back up through the stages, and empty
// stages still take new words. A write to an angle register rebuilds the two matrix
// rows in the coefficient pipeline (sine lookup, two multiply levels, rounding); during
// the rebuild s_tready and cfg_ready are low. Register index 3 is ignored. After reset the
// matrix is the identity for zero angles and no rebuild is needed.
module euler_rotate_project_points_top
    import erpp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // point_x, point_y, point_z
    input  wire logic                 s_tlast,   // last_point
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [55:0]               m_tdata,   // screen_x, screen_y, zero pad
    output logic                      m_tlast,   // last_result
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ANGLE_W-1:0]   cfg_data
);

    coef_set_t                coefs;
    logic                     busy;
    logic signed [OUT_W-1:0]  screen_x, screen_y;

    erpp_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .coefs     (coefs)
    );

    erpp_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hold      (busy),
        .coefs     (coefs),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (signed'(s_tdata[COORD_WIDTH-1:0])),
        .in_y      (signed'(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
        .in_z      (signed'(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (screen_x),
        .out_y     (screen_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0000, screen_y, screen_x};

endmodule
`default_nettype wire

FILE: sv/erpp_coef.sv
// Angle registers and the rebuild pipeline for the two rotation matrix rows.
`default_nettype none
module erpp_coef
    import erpp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ANGLE_W-1:0]   cfg_data,
    output logic                      busy,
    output coef_set_t                 coefs
);

    localparam logic [2:0] REBUILD_CYCLES = 3'd4;
    localparam logic [ANGLE_W:0] DEG_360 = 10'd360;
    localparam logic [ANGLE_W:0] DEG_90  = 10'd90;

    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [TRIP_W-1:0] HALF_T = TRIP_W'(1) <<< (2 * COEF_FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] CMAX_P = PROD_W'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] CMIN_P = -CMAX_P - PROD_W'(1);
    localparam logic signed [TRIP_W-1:0] CMAX_T = TRIP_W'((1 << (COEF_W - 1)) - 1);
    localparam logic signed [TRIP_W-1:0] CMIN_T = -CMAX_T - TRIP_W'(1);

    logic [ANGLE_W-1:0] ang_x_reg, ang_y_reg, ang_z_reg;
    logic [2:0]         cnt_reg;

    logic signed [COEF_W-1:0] sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic signed [PROD_W-1:0] p_cycz_reg, p_cysz_reg, p_sxcy_reg;
    logic signed [PROD_W-1:0] p_sxsy_reg, p_cxsz_reg, p_cxcz_reg;
    logic signed [COEF_W-1:0] m00_reg, m01_reg, m02_reg, m12_reg;
    logic signed [TRIP_W-1:0] m10_sum_reg, m11_sum_reg;
    coef_set_t                coef_reg;

    logic signed [TRIP_W-1:0] m10_sum_next, m11_sum_next;
    logic                     wr;

    // angle reduced mod 360, then folded onto the quarter-wave table
    function automatic logic signed [COEF_W-1:0] sine_of(input logic [ANGLE_W:0] a_raw);
        logic [ANGLE_W:0]     a;
        logic [TAB_IDX_W-1:0] idx;
        logic                 neg;
        logic [COEF_W-1:0]    mag;
        a = (a_raw >= DEG_360) ? a_raw - DEG_360 : a_raw;
        if (a <= 10'd90) begin
            idx = a[TAB_IDX_W-1:0];
            neg = 1'b0;
        end else if (a <= 10'd180) begin
            idx = TAB_IDX_W'(10'd180 - a);
            neg = 1'b0;
        end else if (a <= 10'd270) begin
            idx = TAB_IDX_W'(a - 10'd180);
            neg = 1'b1;
        end else begin
            idx = TAB_IDX_W'(DEG_360 - a);
            neg = 1'b1;
        end
        mag = {1'b0, SINE_TAB[idx]};
        return neg ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic logic [ANGLE_W:0] reduce(input logic [ANGLE_W-1:0] a);
        return ({1'b0, a} >= DEG_360) ? {1'b0, a} - DEG_360 : {1'b0, a};
    endfunction

    function automatic logic signed [COEF_W-1:0] round_p(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = (v + HALF_P) >>> COEF_FRAC_BITS;
        if (r > CMAX_P) begin
            r = CMAX_P;
        end else if (r < CMIN_P) begin
            r = CMIN_P;
        end
        return r[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] round_t(input logic signed [TRIP_W-1:0] v);
        logic signed [TRIP_W-1:0] r;
        r = (v + HALF_T) >>> (2 * COEF_FRAC_BITS);
        if (r > CMAX_T) begin
            r = CMAX_T;
        end else if (r < CMIN_T) begin
            r = CMIN_T;
        end
        return r[COEF_W-1:0];
    endfunction

    assign busy      = (cnt_reg != 3'd0);
    assign cfg_ready = !busy;
    assign wr        = cfg_valid && cfg_ready;
    assign coefs     = coef_reg;

    assign m10_sum_next = TRIP_W'(p_sxsy_reg) * TRIP_W'(cz_reg)
                        + (TRIP_W'(p_cxsz_reg) <<< COEF_FRAC_BITS);
    assign m11_sum_next = (TRIP_W'(p_cxcz_reg) <<< COEF_FRAC_BITS)
                        - TRIP_W'(p_sxsy_reg) * TRIP_W'(sz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_x_reg <= '0;
            ang_y_reg <= '0;
            ang_z_reg <= '0;
            cnt_reg   <= '0;
            coef_reg  <= '{m00: COEF_W'(1 << COEF_FRAC_BITS), m01: '0, m02: '0,
                           m10: '0, m11: COEF_W'(1 << COEF_FRAC_BITS), m12: '0};
        end else begin
            if (wr) begin
                unique case (cfg_index)
                    REG_ROT_X: ang_x_reg <= cfg_data;
                    REG_ROT_Y: ang_y_reg <= cfg_data;
                    REG_ROT_Z: ang_z_reg <= cfg_data;
                    default: ;
                endcase
                if (cfg_index == REG_ROT_X || cfg_index == REG_ROT_Y ||
                    cfg_index == REG_ROT_Z) begin
                    cnt_reg <= REBUILD_CYCLES;
                end
            end else if (busy) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
            // last rebuild step: the row sums are ready
            if (cnt_reg == 3'd1) begin
                coef_reg <= '{m00: m00_reg, m01: m01_reg, m02: m02_reg,
                               m10: round_t(m10_sum_reg), m11: round_t(m11_sum_reg),
                               m12: m12_reg};
            end
        end
    end

    // free-running rebuild pipeline, angles hold still while busy
    always_ff @(posedge aclk) begin
        sx_reg <= sine_of(reduce(ang_x_reg));
        cx_reg <= sine_of(reduce(ang_x_reg) + DEG_90);
        sy_reg <= sine_of(reduce(ang_y_reg));
        cy_reg <= sine_of(reduce(ang_y_reg) + DEG_90);
        sz_reg <= sine_of(reduce(ang_z_reg));
        cz_reg <= sine_of(reduce(ang_z_reg) + DEG_90);

        p_cycz_reg <= PROD_W'(cy_reg) * PROD_W'(cz_reg);
        p_cysz_reg <= PROD_W'(cy_reg) * PROD_W'(sz_reg);
        p_sxcy_reg <= PROD_W'(sx_reg) * PROD_W'(cy_reg);
        p_sxsy_reg <= PROD_W'(sx_reg) * PROD_W'(sy_reg);
        p_cxsz_reg <= PROD_W'(cx_reg) * PROD_W'(sz_reg);
        p_cxcz_reg <= PROD_W'(cx_reg) * PROD_W'(cz_reg);

        m00_reg     <= round_p(p_cycz_reg);
        m01_reg     <= round_p(-p_cysz_reg);
        m02_reg     <= sy_reg;
        m12_reg     <= round_p(-p_sxcy_reg);
        m10_sum_reg <= m10_sum_next;
        m11_sum_reg <= m11_sum_next;
    end

endmodule
`default_nettype wire

FILE: sv/erpp_proj.sv
// Three-stage projection pipeline: multiply, row sums, shift and saturate.
`default_nettype none
module erpp_proj
    import erpp_pkg::*;
(
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          hold,
    input  wire coef_set_t                     coefs,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] in_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_z,
    input  wire logic                          in_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [OUT_W-1:0]            out_x,
    output logic signed [OUT_W-1:0]            out_y,
    output logic                               out_last
);

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [MUL_W-1:0] px0_reg, py0_reg, pz0_reg, px1_reg, py1_reg, pz1_reg;
    logic                    last1_reg, last2_reg, last3_reg;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg;

    logic en1, en2, en3, accept;
    logic signed [ACC_W-1:0] acc_x_next, acc_y_next;

    function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a >>> OUT_FRAC_SHIFT;
        if (s > OUT_MAX) begin
            s = OUT_MAX;
        end else if (s < OUT_MIN) begin
            s = OUT_MIN;
        end
        return s[OUT_W-1:0];
    endfunction

    // each stage moves when its slot is empty or the next one moves
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !hold;
    assign accept   = in_valid && in_ready;

    assign acc_x_next = ACC_W'(px0_reg) + ACC_W'(py0_reg) + ACC_W'(pz0_reg);
    assign acc_y_next = ACC_W'(px1_reg) + ACC_W'(py1_reg) + ACC_W'(pz1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= accept;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            px0_reg   <= MUL_W'(in_x) * MUL_W'(coefs.m00);
            py0_reg   <= MUL_W'(in_y) * MUL_W'(coefs.m01);
            pz0_reg   <= MUL_W'(in_z) * MUL_W'(coefs.m02);
            px1_reg   <= MUL_W'(in_x) * MUL_W'(coefs.m10);
            py1_reg   <= MUL_W'(in_y) * MUL_W'(coefs.m11);
            pz1_reg   <= MUL_W'(in_z) * MUL_W'(coefs.m12);
            last1_reg <= in_last;
        end
        if (en2) begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            last2_reg <= last1_reg;
        end
        if (en3) begin
            out_x_reg <= scale_sat(acc_x_reg);
            out_y_reg <= scale_sat(acc_y_reg);
            last3_reg <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = last3_reg;

endmodule
`default_nettype wire

FILE: dv/euler_rotate_project_points_top_test.sv
// Testbench for the Euler rotation and orthographic projection block.
`default_nettype none
module euler_rotate_project_points_top_test;
    import erpp_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int SCREEN_BITS = 26;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam longint unsigned PI_Q30_DEG = 64'd3373259426;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic signed [SCREEN_BITS-1:0] sx;
        logic signed [SCREEN_BITS-1:0] sy;
        logic                          lst;
    } screen_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;   // point_x, point_y, point_z
    logic                 s_tlast   = 1'b0; // last_point
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;          // screen_x, screen_y, zero pad
    logic                 m_tlast;          // last_result
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_data  = '0;

    // predictor state
    longint      quarter_sine [0:90];
    longint      row_coef [6];
    int unsigned rot_deg [3];
    screen_t     pending_screens [$];

    int unsigned fault_count = 0;
    int unsigned quiet_cycles = 0;
    int          sink_hold_cycles = 0;
    int          sink_gap = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;

    euler_rotate_project_points_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ---------------- predictor ----------------

    // Q2.30 Taylor series, 7 terms past x, then rounded half-up to Q2.14
    function automatic void build_quarter_sine();
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        for (int d = 0; d <= 90; d++) begin
            ang  = (longint'(d) * PI_Q30_DEG) / 64'd180;
            sq   = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            quarter_sine[d] = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        end
    endfunction

    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint sin_deg(int unsigned a);
        int unsigned r;
        r = a % 360;
        if (r <= 90) return quarter_sine[r];
        if (r <= 180) return quarter_sine[180 - r];
        if (r <= 270) return -quarter_sine[r - 180];
        return -quarter_sine[360 - r];
    endfunction

    // round half toward +inf, then saturate to the coefficient width
    function automatic longint round_coef(longint v, int sh);
        return clamp_signed((v + (64'sd1 <<< (sh - 1))) >>> sh, FRAC_BITS + 2);
    endfunction

    function automatic void rebuild_rows();
        longint one;
        longint sx, cx, sy, cy, sz, cz;
        one = 64'sd1 <<< FRAC_BITS;
        sx = sin_deg(rot_deg[0]); cx = sin_deg(rot_deg[0] + 90);
        sy = sin_deg(rot_deg[1]); cy = sin_deg(rot_deg[1] + 90);
        sz = sin_deg(rot_deg[2]); cz = sin_deg(rot_deg[2] + 90);
        row_coef[0] = round_coef(cy * cz, FRAC_BITS);
        row_coef[1] = round_coef(-(cy * sz), FRAC_BITS);
        row_coef[2] = clamp_signed(sy, FRAC_BITS + 2);
        row_coef[3] = round_coef(sx * sy * cz + cx * sz * one, 2 * FRAC_BITS);
        row_coef[4] = round_coef(-(sx * sy * sz) + cx * cz * one, 2 * FRAC_BITS);
        row_coef[5] = round_coef(-(sx * cy), FRAC_BITS);
    endfunction

    function automatic logic signed [SCREEN_BITS-1:0] project_row(
        logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz, int row);
        longint acc;
        acc = longint'(px) * row_coef[3 * row] + longint'(py) * row_coef[3 * row + 1]
            + longint'(pz) * row_coef[3 * row + 2];
        return SCREEN_BITS'(clamp_signed(acc >>> (FRAC_BITS - 8), SCREEN_BITS));
    endfunction

    function automatic screen_t project_point(
        logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz, logic lst);
        screen_t r;
        r.sx  = project_row(px, py, pz, 0);
        r.sy  = project_row(px, py, pz, 1);
        r.lst = lst;
        return r;
    endfunction

    // ---------------- result side ----------------

    always @(posedge aclk) begin : sink
        screen_t                       want;
        logic signed [SCREEN_BITS-1:0] got_x;
        logic signed [SCREEN_BITS-1:0] got_y;
        if (aresetn && m_tvalid && m_tready) begin
            got_x = m_tdata[SCREEN_BITS-1:0];
            got_y = m_tdata[2*SCREEN_BITS-1:SCREEN_BITS];
            if (pending_screens.size() == 0) begin
                $error("result word with nothing expected: screen_x %0d screen_y %0d",
                       got_x, got_y);
                fault_count++;
            end else begin
                want = pending_screens.pop_front();
                if (got_x !== want.sx) begin
                    $error("screen_x expected %0d got %0d", want.sx, got_x);
                    fault_count++;
                end
                if (got_y !== want.sy) begin
                    $error("screen_y expected %0d got %0d", want.sy, got_y);
                    fault_count++;
                end
                if (m_tlast !== want.lst) begin
                    $error("last_result expected %0b got %0b", want.lst, m_tlast);
                    fault_count++;
                end
            end
        end
        // long hold-off first, then random stall bursts
        if (sink_hold_cycles > 0) begin
            m_tready <= 1'b0;
            sink_hold_cycles--;
        end else if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap--;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            sink_gap = $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    // s_tvalid stays high after a word is taken; the next call or drain_points
    // takes it over in the same step
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] pz, input logic lst);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        pending_screens.push_back(project_point(px, py, pz, lst));
    endtask

    task automatic drain_points();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_screens.size() != 0);
    endtask

    task automatic write_angle(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
        drain_points();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROT_X: rot_deg[0] = val;
            REG_ROT_Y: rot_deg[1] = val;
            REG_ROT_Z: rot_deg[2] = val;
            default:   return;
        endcase
        rebuild_rows();
    endtask

    task automatic write_angles(input int unsigned ax, input int unsigned ay,
                                input int unsigned az);
        write_angle(REG_ROT_X, ANGLE_W'(ax));
        write_angle(REG_ROT_Y, ANGLE_W'(ay));
        write_angle(REG_ROT_Z, ANGLE_W'(az));
    endtask

    function automatic logic [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 6))
            0:       return ANGLE_W'(0);
            1:       return ANGLE_W'(359);
            2:       return ANGLE_W'($urandom_range(360, 511));
            3:       return ANGLE_W'(90 * $urandom_range(0, 3));
            default: return ANGLE_W'($urandom_range(0, 359));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2: begin
                v = $urandom_range(0, 64);
                return 16'(v - 32);
            end
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random_points(input int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       (i == count - 1) || ($urandom_range(0, 15) == 0));
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_identity();
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
        send_point(16'sh7fff, 16'sh8000, 16'sh5555, 1'b0);
        send_point(16'sh8000, 16'sh7fff, -16'sh5556, 1'b1);
    endtask

    task automatic test_quadrant_angles();
        write_angles(90, 180, 270);
        send_point(16'sh7fff, 16'sh8000, 16'sd12345, 1'b0);
        send_point(16'sh8000, 16'sh7fff, -16'sd1, 1'b1);
        write_angles(359, 1, 45);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        // angles past a full turn wrap around
        write_angles(360, 450, 511);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sd300, -16'sd200, 16'sd100, 1'b1);
        // spare register index must leave the matrix alone
        write_angle(REG_SPARE, 9'h1ff);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
        send_point(16'sd1, 16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_random_grids();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0) write_angles(0, 0, 0);
            else if (ph == 1) write_angles(359, 359, 359);
            else if (ph == 2) write_angles(511, 511, 511);
            else begin
                if ($urandom_range(0, 3) != 0) write_angle(REG_ROT_X, rand_angle());
                if ($urandom_range(0, 3) != 0) write_angle(REG_ROT_Y, rand_angle());
                if ($urandom_range(0, 3) != 0) write_angle(REG_ROT_Z, rand_angle());
                if ($urandom_range(0, 2) == 0)
                    write_angle(REG_SPARE, ANGLE_W'($urandom_range(0, 511)));
            end
            send_random_points($urandom_range(60, 160));
        end
    endtask

    task automatic test_output_backpressure();
        write_angles(rand_angle(), rand_angle(), rand_angle());
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        // receiver holds off; the pipe fills and s_tready must drop
        sink_hold_cycles = 300;
        send_random_points(40);
        // sender waits for every result before going on
        drain_points();
        send_random_points(10);
    endtask

    task automatic test_full_rate_stream();
        write_angles(rand_angle(), rand_angle(), rand_angle());
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_points(300);
    endtask

    initial begin
        build_quarter_sine();
        rot_deg = '{0, 0, 0};
        rebuild_rows();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_identity();
        test_quadrant_angles();
        test_random_grids();
        test_output_backpressure();
        test_full_rate_stream();

        drain_points();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
